// ===== rtl/lld_pkg.sv =====
// ----------------------------------------------------------------------------
// lld_pkg - shared definitions for the newest-first value list
// Command and status codes, field widths, default sizes and the field write
// enables of the node memory.
// ----------------------------------------------------------------------------
package lld_pkg;

    // Field widths of the command and result transfers
    localparam int CMD_W    = 2;
    localparam int ITEM_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 9;

    // Default sizes
    localparam int LLD_VALUES   = 256;
    localparam int LLD_CAPACITY = 256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Per-field write enables of one node memory word
    typedef struct packed {
        logic value;
        logic older;
        logic newer;
        logic same;
    } node_we_t;

endpackage

// ===== rtl/lld_node_ram.sv =====
// ----------------------------------------------------------------------------
// lld_node_ram - node pool memory
// One word per node: value, older link, newer link and the link to the next
// older occurrence of the same value. One write port with field enables, one
// read port with registered data.
// ----------------------------------------------------------------------------
module lld_node_ram
    import lld_pkg::*;
#(
    parameter int CAPACITY = LLD_CAPACITY,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int PTR_W = IDX_W + 1
)
(
    input  logic              clk,
    input  node_we_t          we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [ITEM_W-1:0] wvalue,
    input  logic [PTR_W-1:0]  wolder,
    input  logic [PTR_W-1:0]  wnewer,
    input  logic [PTR_W-1:0]  wsame,
    input  logic [IDX_W-1:0]  raddr,
    output logic [ITEM_W-1:0] rvalue,
    output logic [PTR_W-1:0]  rolder,
    output logic [PTR_W-1:0]  rnewer,
    output logic [PTR_W-1:0]  rsame
);

    logic [ITEM_W-1:0] value_mem [CAPACITY];
    logic [PTR_W-1:0]  older_mem [CAPACITY];
    logic [PTR_W-1:0]  newer_mem [CAPACITY];
    logic [PTR_W-1:0]  same_mem  [CAPACITY];

    // Write the enabled fields of one node
    always_ff @(posedge clk)
    begin
        if (we.value)
        begin
            value_mem[waddr] <= wvalue;
        end
        if (we.older)
        begin
            older_mem[waddr] <= wolder;
        end
        if (we.newer)
        begin
            newer_mem[waddr] <= wnewer;
        end
        if (we.same)
        begin
            same_mem[waddr] <= wsame;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rvalue <= value_mem[raddr];
        rolder <= older_mem[raddr];
        rnewer <= newer_mem[raddr];
        rsame  <= same_mem[raddr];
    end

endmodule

// ===== rtl/lifo_list_with_delete_by_value.sv =====
// ----------------------------------------------------------------------------
// lifo_list_with_delete_by_value - newest-first value list with delete
// Node pool list with per-value occurrence chains for constant-time search
// and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command and item_value:
//   push, pop head, search value, delete newest occurrence of value.
//   Output channel (out_valid/out_ready) returns one result per command:
//   status, found, removed_value and the entry count after the command.
//   One command is in work at a time. From transfer in, a command steps
//   through S_RD and S_DEC, then S_LINK for a push, S_REL1 to S_REL3 for
//   a pop, S_DNODE and S_REL1 to S_REL3 for a delete, and ends in S_OUT;
//   a search, a push into a full pool, a pop of an empty list or a delete
//   of an absent value goes from S_DEC straight to S_OUT. The block goes
//   back to idle before it takes the next transfer.
//   After reset the value-top table is cleared one entry a cycle, all VALUES
//   entries, with in_ready low. The result sits in an output register; the
//   next command is taken while it waits, and a finished command holds in
//   the output stage until the receiver takes the previous result.
//   Pushing into a full pool, popping an empty list or deleting an absent
//   value changes nothing and reports a status code.
// ----------------------------------------------------------------------------
module lifo_list_with_delete_by_value
    import lld_pkg::*;
#(
    parameter int VALUES   = LLD_VALUES,
    parameter int CAPACITY = LLD_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [ITEM_W-1:0]   item_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [ITEM_W-1:0]   removed_value,
    output logic [ENTRY_W-1:0]  entry_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int PTR_W  = IDX_W + 1;
    localparam int VIDX_W = $clog2(VALUES);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] NIL = {1'b1, {IDX_W{1'b0}}};

    // Sequencer states
    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_CLEAR = 4'd0;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] S_RD    = 4'd2;
    localparam logic [STATE_W-1:0] S_DEC   = 4'd3;
    localparam logic [STATE_W-1:0] S_DNODE = 4'd4;
    localparam logic [STATE_W-1:0] S_LINK  = 4'd5;
    localparam logic [STATE_W-1:0] S_REL1  = 4'd6;
    localparam logic [STATE_W-1:0] S_REL2  = 4'd7;
    localparam logic [STATE_W-1:0] S_REL3  = 4'd8;
    localparam logic [STATE_W-1:0] S_OUT   = 4'd9;

    // Control registers
    logic [STATE_W-1:0] state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]   fresh_reg, fresh_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VIDX_W-1:0]  clr_reg, clr_next;
    logic               out_valid_reg;

    // Command and work registers
    logic [CMD_W-1:0]    cmd_reg;
    logic [ITEM_W-1:0]   v_reg;
    logic [IDX_W-1:0]    n_reg, n_next;
    logic [PTR_W-1:0]    older_reg, older_next;
    logic [PTR_W-1:0]    newer_reg, newer_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    logic [ITEM_W-1:0]   res_removed_reg, res_removed_next;

    // Output registers
    logic [STATUS_W-1:0] status_reg;
    logic                found_reg;
    logic [ITEM_W-1:0]   removed_reg;
    logic [ENTRY_W-1:0]  entry_count_reg;

    // Node memory ports
    node_we_t          node_we;
    logic [IDX_W-1:0]  node_waddr;
    logic [ITEM_W-1:0] node_wvalue;
    logic [PTR_W-1:0]  node_wolder;
    logic [PTR_W-1:0]  node_wnewer;
    logic [PTR_W-1:0]  node_wsame;
    logic [IDX_W-1:0]  node_raddr;
    logic [ITEM_W-1:0] node_rvalue;
    logic [PTR_W-1:0]  node_rolder;
    logic [PTR_W-1:0]  node_rnewer;
    logic [PTR_W-1:0]  node_rsame;

    // Value-top memory ports
    logic [PTR_W-1:0]  vtop_mem [VALUES];
    logic              vt_we;
    logic [VIDX_W-1:0] vt_waddr;
    logic [PTR_W-1:0]  vt_wdata;
    logic [PTR_W-1:0]  vt_q;

    logic              in_xfer;
    logic              load_out;
    logic              v_ok;
    logic [VIDX_W-1:0] v_idx;
    logic [IDX_W-1:0]  fresh_idx;

    assign in_xfer   = in_valid && in_ready;
    assign v_ok      = int'(v_reg) < VALUES;
    assign v_idx     = VIDX_W'(v_reg);
    assign fresh_idx = IDX_W'(fresh_reg);

    lld_node_ram #(
        .CAPACITY (CAPACITY)
    ) u_node_ram (
        .clk    (clk),
        .we     (node_we),
        .waddr  (node_waddr),
        .wvalue (node_wvalue),
        .wolder (node_wolder),
        .wnewer (node_wnewer),
        .wsame  (node_wsame),
        .raddr  (node_raddr),
        .rvalue (node_rvalue),
        .rolder (node_rolder),
        .rnewer (node_rnewer),
        .rsame  (node_rsame)
    );

    // Value-top memory: newest node holding each value
    always_ff @(posedge clk)
    begin
        if (vt_we)
        begin
            vtop_mem[vt_waddr] <= vt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        vt_q <= vtop_mem[v_idx];
    end

    // Sequence the reads and writes of one command
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        free_next        = free_reg;
        fresh_next       = fresh_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        n_next           = n_reg;
        older_next       = older_reg;
        newer_next       = newer_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        node_we          = '0;
        node_waddr       = '0;
        node_wvalue      = '0;
        node_wolder      = NIL;
        node_wnewer      = NIL;
        node_wsame       = NIL;
        node_raddr       = '0;
        vt_we            = 1'b0;
        vt_waddr         = v_idx;
        vt_wdata         = NIL;
        in_ready         = 1'b0;
        load_out         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                vt_we    = 1'b1;
                vt_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VIDX_W'(VALUES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_status_next  = ST_OK;
                    res_found_next   = 1'b0;
                    res_removed_next = '0;
                    state_next       = S_RD;
                end
            end

            // Read the head node for pop, the free-list head for push
            S_RD:
            begin
                node_raddr = (cmd_reg == CMD_POP) ? head_reg[IDX_W-1:0]
                                                  : free_reg[IDX_W-1:0];
                state_next = S_DEC;
            end

            S_DEC:
            begin
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        state_next = S_LINK;
                        if (!v_ok)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end
                        else if (!free_reg[IDX_W])
                        begin
                            n_next    = free_reg[IDX_W-1:0];
                            free_next = node_rolder;
                        end
                        else if (int'(fresh_reg) < CAPACITY)
                        begin
                            n_next     = fresh_idx;
                            fresh_next = fresh_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end
                        if (state_next == S_LINK)
                        begin
                            node_we     = '{value: 1'b1, older: 1'b1,
                                            newer: 1'b1, same: 1'b1};
                            node_waddr  = n_next;
                            node_wvalue = v_reg;
                            node_wolder = head_reg;
                            node_wnewer = NIL;
                            node_wsame  = vt_q;
                            vt_we       = 1'b1;
                            vt_wdata    = {1'b0, n_next};
                            head_next   = {1'b0, n_next};
                            count_next  = count_reg + 1'b1;
                            older_next  = head_reg;
                        end
                    end

                    CMD_POP:
                    begin
                        if (head_reg[IDX_W])
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            n_next           = head_reg[IDX_W-1:0];
                            older_next       = node_rolder;
                            newer_next       = node_rnewer;
                            res_removed_next = node_rvalue;
                            vt_we            = int'(node_rvalue) < VALUES;
                            vt_waddr         = VIDX_W'(node_rvalue);
                            vt_wdata         = node_rsame;
                            state_next       = S_REL1;
                        end
                    end

                    CMD_SEARCH:
                    begin
                        res_found_next = v_ok && !vt_q[IDX_W];
                        state_next     = S_OUT;
                    end

                    default:
                    begin
                        if (!v_ok || vt_q[IDX_W])
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            n_next     = vt_q[IDX_W-1:0];
                            node_raddr = vt_q[IDX_W-1:0];
                            state_next = S_DNODE;
                        end
                    end
                endcase
            end

            // Unhook the deleted node from its value chain
            S_DNODE:
            begin
                older_next = node_rolder;
                newer_next = node_rnewer;
                vt_we      = 1'b1;
                vt_wdata   = node_rsame;
                state_next = S_REL1;
            end

            // Point the old head back at the new head
            S_LINK:
            begin
                if (!older_reg[IDX_W])
                begin
                    node_we.newer = 1'b1;
                    node_waddr    = older_reg[IDX_W-1:0];
                    node_wnewer   = head_reg;
                end
                state_next = S_OUT;
            end

            // Put the node on the free list, fix the head
            S_REL1:
            begin
                node_we.older = 1'b1;
                node_waddr    = n_reg;
                node_wolder   = free_reg;
                free_next     = {1'b0, n_reg};
                if (newer_reg[IDX_W])
                begin
                    head_next = older_reg;
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_REL2;
            end

            // Bridge the newer neighbor to the older one
            S_REL2:
            begin
                if (!newer_reg[IDX_W])
                begin
                    node_we.older = 1'b1;
                    node_waddr    = newer_reg[IDX_W-1:0];
                    node_wolder   = older_reg;
                end
                state_next = S_REL3;
            end

            // Bridge the older neighbor to the newer one
            S_REL3:
            begin
                if (!older_reg[IDX_W])
                begin
                    node_we.newer = 1'b1;
                    node_waddr    = older_reg[IDX_W-1:0];
                    node_wnewer   = newer_reg;
                end
                state_next = S_OUT;
            end

            // Hold until the output register is free
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            head_reg  <= NIL;
            free_reg  <= NIL;
            fresh_reg <= '0;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    // Work registers and command capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= command;
            v_reg   <= item_value;
        end
        n_reg           <= n_next;
        older_reg       <= older_next;
        newer_reg       <= newer_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
    end

    // Output valid: set on load, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg      <= res_status_reg;
            found_reg       <= res_found_reg;
            removed_reg     <= res_removed_reg;
            entry_count_reg <= ENTRY_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_count_reg;

`ifndef SYNTHESIS
    // The list never holds more nodes than the pool
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY && int'(fresh_reg) <= CAPACITY)
        else $error("entry or fresh count beyond pool size");

    // An empty list has no head and a non-empty one has
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (head_reg[IDX_W] == (count_reg == '0)))
        else $error("list head disagrees with entry count");

    // One command at a time: no transfer right after a transfer
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("command taken while another is in work");

    // Empty-pop status only with an empty list
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && res_status_reg == ST_EMPTY |-> count_reg == '0)
        else $error("empty status with entries in the list");

    // A result is never loaded over one that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");
`endif

endmodule

// ===== test/lifo_list_with_delete_by_value_tb.sv =====
// ----------------------------------------------------------------------------
// lifo_list_with_delete_by_value_tb - self-checking bench for the value list
// Drives push, pop, search and delete commands through the valid/ready
// input channel and checks every result against a shadow newest-first list
// kept in plain queues. A directed opening covers empty, absent and edge
// values, then biased random phases fill the pool to full and drain it under
// varying sender gaps and receiver stalls, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module lifo_list_with_delete_by_value_tb
    import lld_pkg::*;
();

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [ITEM_W-1:0] value;
        pace_t             pace;
    } command_entry_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ITEM_W-1:0]   removed;
        logic [ENTRY_W-1:0]  count;
    } list_result_t;

    localparam int HOLD_AFTER_RESULTS = 450;
    localparam int HOLD_CYCLES        = 400;
    localparam int DRAIN_CYCLES       = 20;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    command;
    logic [ITEM_W-1:0]   item_value;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ITEM_W-1:0]   removed_value;
    logic [ENTRY_W-1:0]  entry_count;

    command_entry_t    command_backlog[$];
    list_result_t      awaited_results[$];
    logic [ITEM_W-1:0] shadow_stack[$];

    pace_t cur_pace = PACE_STEADY;
    logic  in_took = 1'b0;
    int    hold_left = 0;
    bit    hold_used = 1'b0;
    int    commands_queued = 0;
    int    commands_accepted = 0;
    int    results_checked = 0;
    int    mismatches = 0;
    int    full_rejects = 0;
    int    empty_pops = 0;
    int    absent_deletes = 0;
    int    search_hits = 0;
    int    deepest = 0;

    lifo_list_with_delete_by_value dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .item_value    (item_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found         (found),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

    always #6 clk = ~clk;

    // Apply one command to the shadow list and return the result it yields
    function automatic list_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic [ITEM_W-1:0] v);
        list_result_t r;
        int           hit;
        r.status  = ST_OK;
        r.found   = 1'b0;
        r.removed = '0;
        hit = -1;
        foreach (shadow_stack[i])
        begin
            if (hit < 0 && shadow_stack[i] == v)
                hit = i;
        end
        case (cmd)
            CMD_PUSH:
            begin
                if (shadow_stack.size() >= LLD_CAPACITY)
                    r.status = ST_FULL;
                else
                    shadow_stack.push_front(v);
            end
            CMD_POP:
            begin
                if (shadow_stack.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed = shadow_stack.pop_front();
            end
            CMD_SEARCH:
                r.found = (hit >= 0);
            default:
            begin
                if (hit < 0)
                    r.status = ST_ABSENT;
                else
                    shadow_stack.delete(hit);
            end
        endcase
        r.count = ENTRY_W'(shadow_stack.size());
        return r;
    endfunction

    function automatic bit sender_pauses(pace_t p);
        if (p == PACE_SENDER_GAPS)
            return $urandom_range(99) < 57;
        if (p == PACE_BOTH)
            return $urandom_range(99) < 10;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls(pace_t p);
        if (p == PACE_RECEIVER_STALLS)
            return $urandom_range(99) < 57;
        if (p == PACE_BOTH)
            return $urandom_range(99) < 10;
        return 1'b0;
    endfunction

    // Mostly a few small values so that searches and deletes hit
    function automatic logic [ITEM_W-1:0] pick_value();
        if ($urandom_range(99) < 70)
            return ITEM_W'($urandom_range(15));
        return ITEM_W'($urandom_range(255));
    endfunction

    task automatic queue_command(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] v, pace_t p);
        command_entry_t e;
        e.command = cmd;
        e.value   = v;
        e.pace    = p;
        command_backlog.push_back(e);
    endtask

    // Queue a run of random commands; weights in percent, delete takes the rest
    task automatic queue_phase(pace_t p, int count, int w_push, int w_pop, int w_search);
        int roll;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < w_push)
                cmd = CMD_PUSH;
            else if (roll < w_push + w_pop)
                cmd = CMD_POP;
            else if (roll < w_push + w_pop + w_search)
                cmd = CMD_SEARCH;
            else
                cmd = CMD_DELETE;
            queue_command(cmd, pick_value(), p);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Offer the next command once the current one has been transferred
    always @(negedge clk)
    begin
        command_entry_t nxt;
        if (rst_n && (!in_valid || in_took))
        begin
            if (command_backlog.size() != 0 && !sender_pauses(command_backlog[0].pace))
            begin
                nxt = command_backlog.pop_front();
                command    <= nxt.command;
                item_value <= nxt.value;
                cur_pace   <= nxt.pace;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Count out the long receiver hold-off once enough results have passed
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_used && results_checked >= HOLD_AFTER_RESULTS)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Stall the result channel per pace, and hard during the hold-off
    always @(negedge clk)
    begin
        out_ready <= (hold_left == 0) && !receiver_stalls(cur_pace);
    end

    // Check each result transfer, then predict for each command transfer
    always @(posedge clk)
    begin
        list_result_t want;
        in_took <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, actual status %0h count %0h",
                         $time, status, entry_count);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", want.status, status);
                check_field("found", want.found, found);
                check_field("removed_value", want.removed, removed_value);
                check_field("entry_count", want.count, entry_count);
            end
        end
        if (in_valid && in_ready)
        begin
            commands_accepted++;
            want = apply_command(command, item_value);
            awaited_results.push_back(want);
            if (want.status == ST_FULL)
                full_rejects++;
            if (want.status == ST_EMPTY)
                empty_pops++;
            if (want.status == ST_ABSENT)
                absent_deletes++;
            if (want.found)
                search_hits++;
            if (want.count > deepest)
                deepest = want.count;
        end
    end

    initial
    begin
        #4000000;
        $display("** lifo_list_with_delete_by_value: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_PUSH;
        item_value = '0;
        out_ready  = 1'b0;

        // Directed: empty list, absent values, edge values, middle and tail deletes
        queue_command(CMD_POP,    8'h00, PACE_STEADY);
        queue_command(CMD_DELETE, 8'h05, PACE_STEADY);
        queue_command(CMD_SEARCH, 8'h05, PACE_STEADY);
        queue_command(CMD_PUSH,   8'h00, PACE_STEADY);
        queue_command(CMD_PUSH,   8'hFF, PACE_STEADY);
        queue_command(CMD_PUSH,   8'hAA, PACE_STEADY);
        queue_command(CMD_PUSH,   8'h55, PACE_STEADY);
        queue_command(CMD_PUSH,   8'hAA, PACE_STEADY);
        queue_command(CMD_PUSH,   8'h55, PACE_STEADY);
        queue_command(CMD_SEARCH, 8'hAA, PACE_STEADY);
        queue_command(CMD_DELETE, 8'hAA, PACE_STEADY);
        queue_command(CMD_SEARCH, 8'hAA, PACE_STEADY);
        queue_command(CMD_DELETE, 8'h00, PACE_STEADY);
        queue_command(CMD_DELETE, 8'hFF, PACE_STEADY);
        queue_command(CMD_POP,    8'hFF, PACE_STEADY);
        queue_command(CMD_POP,    8'h00, PACE_STEADY);
        queue_command(CMD_SEARCH, 8'h55, PACE_STEADY);
        queue_command(CMD_SEARCH, 8'hFF, PACE_STEADY);
        queue_command(CMD_DELETE, 8'hAA, PACE_STEADY);
        queue_command(CMD_DELETE, 8'hAA, PACE_STEADY);
        queue_command(CMD_POP,    8'h7F, PACE_STEADY);

        // Random: mixed, fill past full, drain, drain to empty, mixed again
        queue_phase(PACE_STEADY,          150, 40, 20, 20);
        queue_phase(PACE_SENDER_GAPS,     300, 92,  0,  8);
        queue_phase(PACE_RECEIVER_STALLS, 200, 15, 35, 15);
        queue_phase(PACE_BOTH,            150, 40, 20, 20);
        queue_phase(PACE_STEADY,          250, 20, 40, 10);
        queue_phase(PACE_SENDER_GAPS,     150, 40, 20, 20);
        queue_phase(PACE_RECEIVER_STALLS, 100, 50, 15, 15);
        queue_phase(PACE_BOTH,            100, 35, 25, 15);
        commands_queued = command_backlog.size();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transfer in, every result out, then let the block settle
        while (commands_accepted < commands_queued)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d results, peak list depth %0d.",
                 commands_accepted, results_checked, deepest);
        $display("Full pushes %0d, empty pops %0d, absent deletes %0d, search hits %0d.",
                 full_rejects, empty_pops, absent_deletes, search_hits);
        if (mismatches == 0)
            $display("** lifo_list_with_delete_by_value: PASSED **");
        else
            $display("** lifo_list_with_delete_by_value: FAILED **");
        $finish;
    end

endmodule
